// ===== hw/rtl/ttf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_pkg
// Shared constants, widths and types of the triangle tangent frame unit.
// ----------------------------------------------------------------------------
package ttf_pkg;

    // vertex store
    localparam int VERTEX_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
    localparam int IDX_W        = 12;
    localparam int POS_W        = 32;
    localparam int TEX_W        = 24;
    localparam int VTX_W        = 3 * POS_W + 2 * TEX_W;

    // stream packing
    localparam int S_DATA_W     = 184;
    localparam int M_DATA_W     = 96;
    localparam int OUT_W        = 16;

    // datapath widths
    localparam int E_W          = POS_W + 1;          // position delta
    localparam int D_W          = TEX_W + 1;          // uv delta
    localparam int PROD_W       = E_W + D_W;          // uv delta * edge
    localparam int SUM_W        = PROD_W + 1;         // difference of products
    localparam int DET_W        = 2 * D_W + 1;        // uv determinant
    localparam int MAG_W        = SUM_W - 1;          // component magnitude
    localparam int SH_W         = 30;                 // magnitude after scaling
    localparam int SHIFT_W      = 6;                  // scale shift amount
    localparam int SQ_W         = 2 * SH_W;
    localparam int SSUM_W       = SQ_W + 2;           // sum of three squares
    localparam int ROOT_W       = SSUM_W / 2;         // vector length
    localparam int TRIAL_W      = SSUM_W + 1;
    localparam int FRAC_W       = 14;                 // Q2.14 fraction bits
    localparam int NUM_W        = SH_W + FRAC_W + 1;  // rounded dividend
    localparam int Q_W          = FRAC_W + 1;         // quotient, up to 1.0
    localparam int DT_W         = NUM_W + 1;

    // pipeline depth, accept to output register
    localparam int RAM_LAT      = 1;
    localparam int CROSS_LAT    = 4;
    localparam int UNIT_LAT     = 4 + ROOT_W + 1 + Q_W;
    localparam int TOTAL_LAT    = RAM_LAT + CROSS_LAT + UNIT_LAT + 1;

    typedef enum logic
    {
        CMD_WRITE    = 1'b0,
        CMD_TRIANGLE = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic signed [TEX_W-1:0] u;
        logic signed [TEX_W-1:0] v;
    } vtx_t;

    // unscaled vector, sign and magnitude per component
    typedef struct packed
    {
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
    } vec_t;

    // side data along the square root steps
    typedef struct packed
    {
        logic [2:0][SH_W-1:0] sm;
        logic [2:0]           neg;
        logic                 zero;
        logic                 flag;
    } root_side_t;

    // side data along the divide steps
    typedef struct packed
    {
        logic [ROOT_W-1:0] len;
        logic [2:0]        neg;
        logic              zero;
        logic              flag;
    } div_side_t;

endpackage

// ===== hw/rtl/triangle_tangent_frame_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_frame_top
// Per-triangle unit tangent and bitangent from a vertex store.
//
// Use:
//   s_axis carries commands. tuser = command: a write beat stores one vertex
//   (position Q16.16, uv Q8.16) at first_index and gives no result; a
//   triangle beat reads the three named vertices and gives one m_axis beat
//   with tangent and bitangent in Q2.14, and tuser = degenerate when the uv
//   determinant or either vector is zero (vectors then read as zero).
//   Throughput: one beat per cycle while the output is not stalled, writes
//   and triangles freely mixed; a triangle sees every write accepted before it.
//   The pipeline depth is set by the square root (one bit per stage,
//   31 stages) and the divide (15 stages).
//   The whole pipeline advances together; when the output register holds a
//   beat that is not taken, s_tready drops and everything holds.
//   Reset clears the pipeline valid bits only; vertex entries are undefined
//   until written. There is no clearing pass.
// ----------------------------------------------------------------------------
module triangle_tangent_frame_top
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // first_index, second_index, third_index, pos_x, pos_y, pos_z, tex_u,
    // tex_v, zero pad
    input  logic [ttf_pkg::S_DATA_W-1:0]  s_tdata,
    // command
    input  logic                          s_tuser,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
    output logic [ttf_pkg::M_DATA_W-1:0]  m_tdata,
    // degenerate
    output logic                          m_tuser
);

    localparam int LAT = ttf_pkg::TOTAL_LAT;

    // ---- input unpacking ----
    logic [ttf_pkg::IDX_W-1:0] idx [3];
    ttf_pkg::vtx_t             wr_vtx;
    logic                      accept, en;
    ttf_pkg::cmd_t             cmd;

    always_comb
    begin
        idx[0]   = s_tdata[11:0];
        idx[1]   = s_tdata[23:12];
        idx[2]   = s_tdata[35:24];
        wr_vtx.x = s_tdata[67:36];
        wr_vtx.y = s_tdata[99:68];
        wr_vtx.z = s_tdata[131:100];
        wr_vtx.u = s_tdata[155:132];
        wr_vtx.v = s_tdata[179:156];
        cmd      = ttf_pkg::cmd_t'(s_tuser);
    end

    // one global advance: the output register is free or being emptied
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;

    // ---- vertex store: three copies, one read port each ----
    logic [ttf_pkg::ADDR_W-1:0] addr [3];
    logic [2:0]                 in_range;
    logic [2:0]                 in_range_reg;
    logic [ttf_pkg::VTX_W-1:0]  rd_word [3];
    ttf_pkg::vtx_t              rd_vtx [3];
    logic                       wr_en;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            addr[i]     = ttf_pkg::ADDR_W'(32'(idx[i]));
            in_range[i] = (32'(idx[i]) < 32'(ttf_pkg::VERTEX_DEPTH));
        end
    end

    // out-of-range writes are dropped
    assign wr_en = accept && (cmd == ttf_pkg::CMD_WRITE) && in_range[0];

    for (genvar r = 0; r < 3; r++)
    begin : g_store
        ttf_vertex_ram
        #(
            .DEPTH (ttf_pkg::VERTEX_DEPTH),
            .WIDTH (ttf_pkg::VTX_W)
        )
        u_ram
        (
            .clk   (clk),
            .we    (wr_en),
            .waddr (addr[0]),
            .wdata (wr_vtx),
            .re    (en),
            .raddr (addr[r]),
            .rdata (rd_word[r])
        );

        // out-of-range entries read as zero
        assign rd_vtx[r] = in_range_reg[r] ? ttf_pkg::vtx_t'(rd_word[r]) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_range_reg <= in_range;
        end
    end

    // ---- valid pipeline ----
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], accept && (cmd == ttf_pkg::CMD_TRIANGLE)};
        end
    end

    // ---- datapath ----
    ttf_pkg::vec_t tan_vec, bitan_vec;
    logic          det_zero;

    ttf_cross u_cross
    (
        .clk       (clk),
        .en        (en),
        .vtx_a     (rd_vtx[0]),
        .vtx_b     (rd_vtx[1]),
        .vtx_c     (rd_vtx[2]),
        .tan_vec   (tan_vec),
        .bitan_vec (bitan_vec),
        .det_zero  (det_zero)
    );

    logic [2:0][ttf_pkg::Q_W-1:0] t_q, b_q;
    logic [2:0]                   t_neg, b_neg;
    logic                         t_zero, b_zero, det_zero_d, b_flag;

    ttf_unitize u_unit_tan
    (
        .clk      (clk),
        .en       (en),
        .vin      (tan_vec),
        .flag_in  (det_zero),
        .quot     (t_q),
        .neg      (t_neg),
        .zero     (t_zero),
        .flag_out (det_zero_d)
    );

    ttf_unitize u_unit_bitan
    (
        .clk      (clk),
        .en       (en),
        .vin      (bitan_vec),
        .flag_in  (1'b0),
        .quot     (b_q),
        .neg      (b_neg),
        .zero     (b_zero),
        .flag_out (b_flag)
    );

    // ---- output register ----
    logic                                degen;
    logic [5:0][ttf_pkg::OUT_W-1:0]      comp_next;
    logic [ttf_pkg::M_DATA_W-1:0]        data_reg;
    logic                                degen_reg;

    always_comb
    begin
        degen = det_zero_d || t_zero || b_zero || b_flag;
        for (int i = 0; i < 3; i++)
        begin
            comp_next[i]     = t_neg[i] ? -ttf_pkg::OUT_W'(t_q[i]) : ttf_pkg::OUT_W'(t_q[i]);
            comp_next[3 + i] = b_neg[i] ? -ttf_pkg::OUT_W'(b_q[i]) : ttf_pkg::OUT_W'(b_q[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg  <= degen ? '0 : comp_next;
            degen_reg <= degen;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = data_reg;
    assign m_tuser  = degen_reg;

    // ---- checks ----
    logic range_ok;

    always_comb
    begin
        range_ok = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            if (($signed(m_tdata[i*16 +: 16]) > 16'sd16384) ||
                ($signed(m_tdata[i*16 +: 16]) < -16'sd16384))
            begin
                range_ok = 1'b0;
            end
        end
    end

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate beat carries nonzero vectors");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> range_ok)
        else $error("output component beyond unit range");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ttf_pkg::CMD_WRITE) |=> !vld_reg[0])
        else $error("vertex write entered the result pipeline");

endmodule

// ===== hw/rtl/ttf_vertex_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_vertex_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ttf_vertex_ram
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ttf_cross.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_cross
// Edges, uv deltas, determinant and unscaled tangent / bitangent (4 stages).
// ----------------------------------------------------------------------------
module ttf_cross
(
    input  logic          clk,
    input  logic          en,
    input  ttf_pkg::vtx_t vtx_a,
    input  ttf_pkg::vtx_t vtx_b,
    input  ttf_pkg::vtx_t vtx_c,
    output ttf_pkg::vec_t tan_vec,
    output ttf_pkg::vec_t bitan_vec,
    output logic          det_zero
);

    logic signed [ttf_pkg::POS_W-1:0]  pa [3];
    logic signed [ttf_pkg::POS_W-1:0]  pb [3];
    logic signed [ttf_pkg::POS_W-1:0]  pc [3];

    logic signed [ttf_pkg::E_W-1:0]    e1_reg [3];
    logic signed [ttf_pkg::E_W-1:0]    e2_reg [3];
    logic signed [ttf_pkg::D_W-1:0]    du1_reg, dv1_reg, du2_reg, dv2_reg;

    logic signed [ttf_pkg::PROD_W-1:0] tp1_reg [3];
    logic signed [ttf_pkg::PROD_W-1:0] tp2_reg [3];
    logic signed [ttf_pkg::PROD_W-1:0] bp1_reg [3];
    logic signed [ttf_pkg::PROD_W-1:0] bp2_reg [3];
    logic signed [ttf_pkg::DET_W-1:0]  dp1_reg, dp2_reg;

    logic signed [ttf_pkg::SUM_W-1:0]  t_reg [3];
    logic signed [ttf_pkg::SUM_W-1:0]  b_reg [3];
    logic signed [ttf_pkg::DET_W-1:0]  det_reg;

    ttf_pkg::vec_t tan_reg, bitan_reg;
    logic          det_zero_reg;

    logic signed [ttf_pkg::SUM_W-1:0]  t_abs [3];
    logic signed [ttf_pkg::SUM_W-1:0]  b_abs [3];

    always_comb
    begin
        pa[0] = vtx_a.x; pa[1] = vtx_a.y; pa[2] = vtx_a.z;
        pb[0] = vtx_b.x; pb[1] = vtx_b.y; pb[2] = vtx_b.z;
        pc[0] = vtx_c.x; pc[1] = vtx_c.y; pc[2] = vtx_c.z;
    end

    // stage 1: deltas from the first vertex
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= ttf_pkg::E_W'(pb[i]) - ttf_pkg::E_W'(pa[i]);
                e2_reg[i] <= ttf_pkg::E_W'(pc[i]) - ttf_pkg::E_W'(pa[i]);
            end
            du1_reg <= ttf_pkg::D_W'(vtx_b.u) - ttf_pkg::D_W'(vtx_a.u);
            dv1_reg <= ttf_pkg::D_W'(vtx_b.v) - ttf_pkg::D_W'(vtx_a.v);
            du2_reg <= ttf_pkg::D_W'(vtx_c.u) - ttf_pkg::D_W'(vtx_a.u);
            dv2_reg <= ttf_pkg::D_W'(vtx_c.v) - ttf_pkg::D_W'(vtx_a.v);
        end
    end

    // stage 2: products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tp1_reg[i] <= ttf_pkg::PROD_W'(dv2_reg) * ttf_pkg::PROD_W'(e1_reg[i]);
                tp2_reg[i] <= ttf_pkg::PROD_W'(dv1_reg) * ttf_pkg::PROD_W'(e2_reg[i]);
                bp1_reg[i] <= ttf_pkg::PROD_W'(du1_reg) * ttf_pkg::PROD_W'(e2_reg[i]);
                bp2_reg[i] <= ttf_pkg::PROD_W'(du2_reg) * ttf_pkg::PROD_W'(e1_reg[i]);
            end
            dp1_reg <= ttf_pkg::DET_W'(du1_reg) * ttf_pkg::DET_W'(dv2_reg);
            dp2_reg <= ttf_pkg::DET_W'(du2_reg) * ttf_pkg::DET_W'(dv1_reg);
        end
    end

    // stage 3: differences
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t_reg[i] <= ttf_pkg::SUM_W'(tp1_reg[i]) - ttf_pkg::SUM_W'(tp2_reg[i]);
                b_reg[i] <= ttf_pkg::SUM_W'(bp1_reg[i]) - ttf_pkg::SUM_W'(bp2_reg[i]);
            end
            det_reg <= dp1_reg - dp2_reg;
        end
    end

    // stage 4: sign (flipped by a negative determinant) and magnitude
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_abs[i] = t_reg[i][ttf_pkg::SUM_W-1] ? -t_reg[i] : t_reg[i];
            b_abs[i] = b_reg[i][ttf_pkg::SUM_W-1] ? -b_reg[i] : b_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tan_reg.neg[i]   <= t_reg[i][ttf_pkg::SUM_W-1] ^ det_reg[ttf_pkg::DET_W-1];
                tan_reg.mag[i]   <= t_abs[i][ttf_pkg::MAG_W-1:0];
                bitan_reg.neg[i] <= b_reg[i][ttf_pkg::SUM_W-1] ^ det_reg[ttf_pkg::DET_W-1];
                bitan_reg.mag[i] <= b_abs[i][ttf_pkg::MAG_W-1:0];
            end
            det_zero_reg <= (det_reg == '0);
        end
    end

    assign tan_vec   = tan_reg;
    assign bitan_vec = bitan_reg;
    assign det_zero  = det_zero_reg;

endmodule

// ===== hw/rtl/ttf_unitize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_unitize
// Pipelined normalization of one vector to Q2.14: scale, squares, square
// root one bit per stage, rounded divide one quotient bit per stage.
// ----------------------------------------------------------------------------
module ttf_unitize
(
    input  logic                           clk,
    input  logic                           en,
    input  ttf_pkg::vec_t                  vin,
    input  logic                           flag_in,
    output logic [2:0][ttf_pkg::Q_W-1:0]   quot,
    output logic [2:0]                     neg,
    output logic                           zero,
    output logic                           flag_out
);

    localparam int RW = ttf_pkg::ROOT_W;
    localparam int QW = ttf_pkg::Q_W;

    // stage A: shift amount from the highest set bit of all three
    logic [ttf_pkg::MAG_W-1:0]   or_all;
    logic [ttf_pkg::SHIFT_W:0]   blen;
    logic [ttf_pkg::SHIFT_W-1:0] shift_next;

    ttf_pkg::vec_t               a_vec_reg;
    logic [ttf_pkg::SHIFT_W-1:0] a_shift_reg;
    logic                        a_zero_reg, a_flag_reg;

    always_comb
    begin
        or_all = vin.mag[0] | vin.mag[1] | vin.mag[2];
        blen   = '0;
        for (int k = 0; k < ttf_pkg::MAG_W; k++)
        begin
            if (or_all[k])
            begin
                blen = (ttf_pkg::SHIFT_W + 1)'(k + 1);
            end
        end
        shift_next = (blen > (ttf_pkg::SHIFT_W + 1)'(ttf_pkg::SH_W))
                   ? ttf_pkg::SHIFT_W'(blen - (ttf_pkg::SHIFT_W + 1)'(ttf_pkg::SH_W))
                   : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_vec_reg   <= vin;
            a_shift_reg <= shift_next;
            a_zero_reg  <= (or_all == '0);
            a_flag_reg  <= flag_in;
        end
    end

    // stage B: scaled magnitudes
    ttf_pkg::root_side_t b_side_reg, c_side_reg;
    logic [ttf_pkg::MAG_W-1:0] shifted [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            shifted[i] = a_vec_reg.mag[i] >> a_shift_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                b_side_reg.sm[i] <= shifted[i][ttf_pkg::SH_W-1:0];
            end
            b_side_reg.neg  <= a_vec_reg.neg;
            b_side_reg.zero <= a_zero_reg;
            b_side_reg.flag <= a_flag_reg;
        end
    end

    // stage C: squares
    logic [ttf_pkg::SQ_W-1:0] sq_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= ttf_pkg::SQ_W'(b_side_reg.sm[i]) * ttf_pkg::SQ_W'(b_side_reg.sm[i]);
            end
            c_side_reg <= b_side_reg;
        end
    end

    // stage D: sum of squares, start of the root chain
    logic [ttf_pkg::SSUM_W-1:0] rem_reg  [RW+1];
    logic [RW-1:0]              root_reg [RW+1];
    ttf_pkg::root_side_t        rside_reg [RW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= ttf_pkg::SSUM_W'(sq_reg[0]) + ttf_pkg::SSUM_W'(sq_reg[1])
                         + ttf_pkg::SSUM_W'(sq_reg[2]);
            root_reg[0] <= '0;
            rside_reg[0] <= c_side_reg;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < RW; k++)
    begin : g_root
        localparam int BP = RW - 1 - k;
        logic [ttf_pkg::TRIAL_W-1:0] trial;
        logic                        fits;

        always_comb
        begin
            trial = (ttf_pkg::TRIAL_W'(root_reg[k]) << (BP + 1))
                  + (ttf_pkg::TRIAL_W'(1) << (2 * BP));
            fits  = ({1'b0, rem_reg[k]} >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]   <= fits ? ttf_pkg::SSUM_W'({1'b0, rem_reg[k]} - trial)
                                       : rem_reg[k];
                root_reg[k+1]  <= fits ? (root_reg[k] | (RW'(1) << BP)) : root_reg[k];
                rside_reg[k+1] <= rside_reg[k];
            end
        end
    end

    // rounded dividend m * 2^14 + floor(len / 2)
    logic [2:0][ttf_pkg::NUM_W-1:0] drem_reg [QW+1];
    logic [2:0][QW-1:0]             dq_reg   [QW+1];
    ttf_pkg::div_side_t             dside_reg [QW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                drem_reg[0][i] <= ttf_pkg::NUM_W'({rside_reg[RW].sm[i],
                                                   {ttf_pkg::FRAC_W{1'b0}}})
                                + ttf_pkg::NUM_W'(root_reg[RW] >> 1);
            end
            dq_reg[0]         <= '0;
            dside_reg[0].len  <= root_reg[RW];
            dside_reg[0].neg  <= rside_reg[RW].neg;
            dside_reg[0].zero <= rside_reg[RW].zero;
            dside_reg[0].flag <= rside_reg[RW].flag;
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar j = 0; j < QW; j++)
    begin : g_div
        localparam int BQ = QW - 1 - j;
        logic [ttf_pkg::DT_W-1:0] dtrial;
        logic [2:0]               dfits;

        always_comb
        begin
            dtrial = ttf_pkg::DT_W'(dside_reg[j].len) << BQ;
            for (int i = 0; i < 3; i++)
            begin
                dfits[i] = ({1'b0, drem_reg[j][i]} >= dtrial);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[j+1][i] <= dfits[i]
                        ? ttf_pkg::NUM_W'({1'b0, drem_reg[j][i]} - dtrial)
                        : drem_reg[j][i];
                    dq_reg[j+1][i]   <= dfits[i] ? (dq_reg[j][i] | (QW'(1) << BQ))
                                                 : dq_reg[j][i];
                end
                dside_reg[j+1] <= dside_reg[j];
            end
        end
    end

    assign quot     = dq_reg[QW];
    assign neg      = dside_reg[QW].neg;
    assign zero     = dside_reg[QW].zero;
    assign flag_out = dside_reg[QW].flag;

endmodule

// ===== bench/triangle_tangent_frame_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_frame_top_tb
// Self-checking bench for the triangle tangent frame unit.
//
// Vertex writes and triangle beats go in on s_axis, with random gaps and
// random output stalls. A local vertex store and predictor work out the
// expected tangent, bitangent and degenerate flag for every triangle, and a
// scoreboard compares each m_axis beat, field by field, in order.
// ----------------------------------------------------------------------------
module triangle_tangent_frame_top_tb;

    localparam int CLK_HALF   = 6;
    localparam int RANDOM_N   = 1700;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 80;
    localparam int POOL       = 64;     // most random work on a few entries

    typedef struct packed
    {
        logic signed [15:0] tx, ty, tz, bx, by, bz;
        logic               degen;
    } frame_t;

    // ------------------------------------------------------------------
    // Scoreboard: holds the predicted frames, compares outgoing beats
    // ------------------------------------------------------------------
    class frame_board;
        frame_t pending[$];
        int     errors;
        int     checked;

        task report_mismatch(string what, longint got, longint want);
            errors++;
            $display("MISMATCH %s: got %0d expected %0d (frame %0d)",
                     what, got, want, checked);
        endtask

        function void note(frame_t f);
            pending = {pending, f};
        endfunction

        task check(frame_t got);
            frame_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("beat with nothing pending", 0, 0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.tx !== want.tx) report_mismatch("tangent_x", got.tx, want.tx);
            if (got.ty !== want.ty) report_mismatch("tangent_y", got.ty, want.ty);
            if (got.tz !== want.tz) report_mismatch("tangent_z", got.tz, want.tz);
            if (got.bx !== want.bx) report_mismatch("bitangent_x", got.bx, want.bx);
            if (got.by !== want.by) report_mismatch("bitangent_y", got.by, want.by);
            if (got.bz !== want.bz) report_mismatch("bitangent_z", got.bz, want.bz);
            if (got.degen !== want.degen)
                report_mismatch("degenerate", got.degen, want.degen);
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [ttf_pkg::S_DATA_W-1:0]  s_tdata;
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [ttf_pkg::M_DATA_W-1:0]  m_tdata;
    logic                          m_tuser;

    triangle_tangent_frame_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    frame_board board;

    // local copy of the vertex store, with a written mark per entry
    ttf_pkg::vtx_t vstore[ttf_pkg::VERTEX_DEPTH];
    bit            written[ttf_pkg::VERTEX_DEPTH];

    int send_idle_pct;
    int recv_idle_pct;
    longint cycles;
    int writes_sent, tris_sent, degen_seen;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // run-length watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("triangle_tangent_frame_top_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // scale a vector to Q2.14; returns 0 for the zero vector
    function automatic bit to_unit(input longint c[3], output logic signed [15:0] o[3]);
        longint unsigned mag[3], top, sum, len, q;
        int s;
        top = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = c[i] < 0 ? -c[i] : c[i];
            if (mag[i] > top) top = mag[i];
        end
        if (top == 0) return 0;
        s = 0;
        while ((top >> s) >= (64'd1 << 30)) s++;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] >>= s;
            sum += mag[i] * mag[i];
        end
        len = root_floor(sum);
        if (len == 0) return 0;
        for (int i = 0; i < 3; i++)
        begin
            q = (mag[i] * 16384 + len / 2) / len;
            o[i] = c[i] < 0 ? -$signed(q[15:0]) : q[15:0];
        end
        return 1;
    endfunction

    function automatic frame_t tangent_frame(int i1, int i2, int i3);
        frame_t f;
        ttf_pkg::vtx_t p1, p2, p3;
        longint e1[3], e2[3], t[3], b[3];
        longint du1, dv1, du2, dv2, det;
        logic signed [15:0] tn[3], bn[3];
        bit bad;
        p1 = vstore[i1];
        p2 = vstore[i2];
        p3 = vstore[i3];
        e1[0] = longint'(p2.x) - p1.x;  e2[0] = longint'(p3.x) - p1.x;
        e1[1] = longint'(p2.y) - p1.y;  e2[1] = longint'(p3.y) - p1.y;
        e1[2] = longint'(p2.z) - p1.z;  e2[2] = longint'(p3.z) - p1.z;
        du1 = longint'(p2.u) - p1.u;
        dv1 = longint'(p2.v) - p1.v;
        du2 = longint'(p3.u) - p1.u;
        dv2 = longint'(p3.v) - p1.v;
        det = du1 * dv2 - du2 * dv1;
        for (int i = 0; i < 3; i++)
        begin
            t[i] = dv2 * e1[i] - dv1 * e2[i];
            b[i] = du1 * e2[i] - du2 * e1[i];
            if (det < 0)
            begin
                t[i] = -t[i];
                b[i] = -b[i];
            end
        end
        bad = (det == 0);
        if (!bad) bad = !to_unit(t, tn);
        if (!bad) bad = !to_unit(b, bn);
        f = '0;
        f.degen = bad;
        if (!bad)
        begin
            f.tx = tn[0]; f.ty = tn[1]; f.tz = tn[2];
            f.bx = bn[0]; f.by = bn[1]; f.bz = bn[2];
        end
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Present one beat from a falling edge and hold it until accepted.
    task automatic push_beat(ttf_pkg::cmd_t cmd, int i1, int i2, int i3,
                             ttf_pkg::vtx_t v);
        while (($urandom % 100) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'd0, v.v, v.u, v.z, v.y, v.x,
                     i3[11:0], i2[11:0], i1[11:0]};
        do @(posedge clk); while (!s_tready);
        // beat taken at this edge: update the local store and predict
        if (cmd == ttf_pkg::CMD_WRITE)
        begin
            vstore[i1]  = v;
            written[i1] = 1'b1;
            writes_sent++;
        end
        else
        begin
            board.note(tangent_frame(i1, i2, i3));
            tris_sent++;
        end
        @(negedge clk);
    endtask

    task automatic put_vertex(int idx, ttf_pkg::vtx_t v);
        push_beat(ttf_pkg::CMD_WRITE, idx, $urandom_range(4095), $urandom_range(4095), v);
    endtask

    task automatic put_triangle(int a, int b, int c);
        ttf_pkg::vtx_t junk;
        junk = ttf_pkg::VTX_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        push_beat(ttf_pkg::CMD_TRIANGLE, a, b, c, junk);
    endtask

    // wait for every predicted frame, no new input meanwhile
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    function automatic ttf_pkg::vtx_t rand_vertex();
        ttf_pkg::vtx_t v;
        int shape;
        shape = $urandom_range(3);
        v.x = $urandom; v.y = $urandom; v.z = $urandom;
        v.u = 24'($urandom); v.v = 24'($urandom);
        if (shape == 0)
        begin
            // small, mesh-like coordinates
            v.x = $signed($urandom_range(2000)) - 1000;
            v.y = $signed($urandom_range(2000)) - 1000;
            v.z = $signed($urandom_range(2000)) - 1000;
            v.u = 24'($signed($urandom_range(200)) - 100);
            v.v = 24'($signed($urandom_range(200)) - 100);
        end
        else if (shape == 1)
        begin
            v.u = 24'($signed($urandom_range(8)) - 4);     // near-degenerate uv
        end
        return v;
    endfunction

    // pick an index that has been written
    function automatic int pick_entry(ref int used[$]);
        return used[$urandom_range(used.size() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls, check at the rising edge
    // ------------------------------------------------------------------
    always @(negedge clk)
        if (rst_n) m_tready <= (($urandom % 100) >= recv_idle_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
        begin
            if (m_tuser) degen_seen++;
            board.check({m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                         m_tdata[63:48], m_tdata[79:64], m_tdata[95:80], m_tuser});
        end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int used[$];
        ttf_pkg::vtx_t v;
        int a, b, c, phase_len;

        board = new();
        cycles = 0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ttf_pkg::CMD_WRITE;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, simple frame, degenerate cases, far indexes
        v = '{x: 32'sh7fffffff, y: 32'sh80000000, z: 32'sh7fffffff,
              u: 24'sh7fffff, v: 24'sh800000};
        put_vertex(0, v);
        v = '{x: 32'sh80000000, y: 32'sh7fffffff, z: 32'sh80000000,
              u: 24'sh800000, v: 24'sh7fffff};
        put_vertex(4095, v);
        v = '{x: 0, y: 32'sh7fffffff, z: 32'sh80000000,
              u: 24'sh7fffff, v: 24'sh7fffff};
        put_vertex(2048, v);
        put_triangle(0, 4095, 2048);          // widest deltas in every field
        put_triangle(4095, 2048, 0);
        v = '0;
        put_vertex(1, v);
        v = '{x: 32'h10000, y: 0, z: 0, u: 24'h10000, v: '0};
        put_vertex(2, v);
        v = '{x: 0, y: 32'h10000, z: 0, u: '0, v: 24'h10000};
        put_vertex(3, v);
        put_triangle(1, 2, 3);                // unit square frame
        put_triangle(1, 3, 2);                // negative determinant
        put_triangle(1, 1, 1);                // zero determinant
        put_triangle(1, 2, 2);
        v = '{x: 0, y: 0, z: 0, u: 24'h20000, v: 24'h10000};
        put_vertex(4, v);
        put_triangle(1, 2, 4);                // uv fine, opposed tangent and bitangent
        v = '{x: 32'h10000, y: 0, z: 0, u: '0, v: 24'h10000};
        put_vertex(5, v);
        put_triangle(1, 2, 5);                // collinear edges
        put_triangle(0, 0, 4095);
        v = '{x: 32'sh12345678, y: 32'shedcba987, z: 32'sh55aa55aa,
              u: 24'sh0aa55a, v: 24'sh355aa5};
        put_vertex(7, v);                     // write an entry right before use
        put_triangle(7, 2, 3);
        put_triangle(2048, 7, 4095);
        drain();

        for (int i = 0; i < 8; i++) used = {used, (i == 6) ? 4095 : i};
        used = {used, 2048};

        // random: three idling phases, writes mixed with triangles
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 87 : 0;
            recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 19 : 0;
            phase_len = RANDOM_N / 3;
            for (int n = 0; n < phase_len; n++)
            begin
                if (n == phase_len / 2)
                    drain();                  // sender holds until all frames out
                if (($urandom % 100) < 35)
                begin
                    a = (($urandom % 4) == 0) ? $urandom_range(4095)
                                              : $urandom_range(POOL - 1);
                    put_vertex(a, rand_vertex());
                    if (!written[a] || used.size() < 4096) used = {used, a};
                end
                else
                begin
                    a = pick_entry(used);
                    b = pick_entry(used);
                    c = pick_entry(used);
                    if (($urandom % 10) == 0) b = a;
                    put_triangle(a, b, c);
                end
            end
        end

        drain();
        $display("covered %0d vertex writes and %0d triangles (%0d degenerate)",
                 writes_sent, tris_sent, degen_seen);
        $display("checked %0d frames under three stall patterns", board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("triangle_tangent_frame_top_tb OK");
        else
            $display("triangle_tangent_frame_top_tb NOT OK");
        $finish;
    end

endmodule
